// ----- src/vgm_pkg.sv -----
// Package for the volume gradient magnitude block: sizes, register codes,
// controller states and the dimension clamp. No dependencies.
`default_nettype none

package vgm_pkg;

  localparam int unsigned MAX_X = 256;
  localparam int unsigned MAX_Y = 256;
  localparam int unsigned MAX_Z = 256;

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = $clog2(MAX_Z);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned PLANE_CELLS = MAX_X * MAX_Y;
  localparam int unsigned PEND_W = AW + 1;

  localparam int unsigned DIM_W = 9;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IN_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned SQ_W = 2 * SAMPLE_W;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned RAD_W = SUM_W + 4;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned MAG_W = 19;
  localparam int unsigned OUT_TDATA_W = ((MAG_W + 7) / 8) * 8;
  localparam int unsigned STEP_W = 3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_Z  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
  localparam logic [DIM_W-1:0] DIM_MAX_X = DIM_W'(MAX_X);
  localparam logic [DIM_W-1:0] DIM_MAX_Y = DIM_W'(MAX_Y);
  localparam logic [DIM_W-1:0] DIM_MAX_Z = DIM_W'(MAX_Z);

  // neighbour reads, in issue order
  localparam logic [STEP_W-1:0] NB_LEFT  = 3'd0;
  localparam logic [STEP_W-1:0] NB_RIGHT = 3'd1;
  localparam logic [STEP_W-1:0] NB_UP    = 3'd2;
  localparam logic [STEP_W-1:0] NB_DOWN  = 3'd3;
  localparam logic [STEP_W-1:0] NB_DONE  = 3'd4;
  localparam logic [STEP_W-1:0] SQ_DONE  = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_OUT
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/vgm_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on vgm_pkg for operand and root widths.
`default_nettype none

module vgm_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vgm_pkg::RAD_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [vgm_pkg::ROOT_W-1:0]  root_o
);
  import vgm_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROOT_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]  trial_rem;
  logic [REM_W+1:0]  trial_sub;

  always_comb begin
    trial_rem = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial_sub = (REM_W+2)'({root_q, 2'b01});
    if (trial_rem >= trial_sub) begin
      rem_d  = REM_W'(trial_rem - trial_sub);
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = REM_W'(trial_rem);
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_CNT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- src/volume_gradient_magnitude_top.sv -----
// Top level of the volume gradient magnitude block: plane stores, pointers,
// controller and output register. Depends on vgm_pkg and vgm_isqrt.
//
// Voxels arrive in raster order (x fastest, then y, then z) and each result
// is the floor of four times the central-difference gradient magnitude of
// the voxel one plane earlier, so the first plane after reset or after any
// register write gives nothing; drain requests flush the last plane of a
// volume. A request that gives a result occupies the block for the centre and
// four neighbour reads through the single read port of the plane stores,
// the squares of the three differences on one multiplier, and the square
// root, which settles one bit per cycle. The next request is taken while a
// finished result waits at the output. The plane stores are not cleared
// after reset. Registers are written only while the block is idle.
`default_nettype none

module volume_gradient_magnitude_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [vgm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] sample
  input  logic                             s_axis_tuser,  // [0] kind (1: drain)
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [vgm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [18:0] magnitude
  output logic                             m_axis_tlast,  // volume end
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vgm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vgm_pkg::DIM_W-1:0]        cfg_data_i
);
  import vgm_pkg::*;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;

  logic [DIM_W-1:0]  width_q, height_q, depth_q;
  logic [DIM_W-1:0]  width_d, height_d, depth_d;
  logic [PEND_W-1:0] plane_q;
  logic [PEND_W-1:0] pending_q;
  logic [XW-1:0]     wx_q, ex_q;
  logic [YW-1:0]     wy_q, ey_q;
  logic [ZW-1:0]     wz_q, ez_q;
  logic              bank_q;

  logic cfg_we, cfg_hit;
  logic acc, acc_voxel, acc_emit;
  logic voxel_emit, drain_due;
  logic ex_wrap, ey_wrap, ez_wrap;
  logic wx_wrap, wy_wrap, wz_wrap;

  logic [AW-1:0]              item_idx_q;
  logic [2:0]                 inner_q;
  logic signed [SAMPLE_W-1:0] next_smp_q;
  logic                       cur_bank_q;
  logic                       last_vox_q;

  logic [SAMPLE_W-1:0] older_mem [PLANE_CELLS];
  logic [SAMPLE_W-1:0] newer_mem [PLANE_CELLS];
  logic [SAMPLE_W-1:0] older_rd_q, newer_rd_q;
  logic [AW-1:0]       rd_addr, wr_addr, nb_addr;
  logic                we_older, we_newer;

  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [SAMPLE_W-1:0] nb_q [4];
  logic signed [SAMPLE_W-1:0] cur_rd;
  logic [1:0]                 nb_sel;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]            sq_q;
  logic [SUM_W-1:0]           sum_q;

  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  logic             out_free, out_load;
  logic             m_valid_q;
  logic [MAG_W-1:0] mag_q;
  logic             tlast_q;

  // ---------------------------------------------------------------- control
  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign cfg_hit = cfg_we && (cfg_index_i == REG_WIDTH_X || cfg_index_i == REG_HEIGHT_Y ||
                              cfg_index_i == REG_DEPTH_Z);

  assign acc        = s_axis_tvalid && s_axis_tready;
  assign acc_voxel  = acc && !s_axis_tuser;
  assign voxel_emit = (pending_q == plane_q);
  assign drain_due  = (pending_q != '0) && (DIM_W'(ez_q) + 1'b1 == depth_q);
  assign acc_emit   = acc && (s_axis_tuser ? drain_due : voxel_emit);

  assign ex_wrap = (DIM_W'(ex_q) + 1'b1 >= width_q);
  assign ey_wrap = (DIM_W'(ey_q) + 1'b1 >= height_q);
  assign ez_wrap = (DIM_W'(ez_q) + 1'b1 >= depth_q);
  assign wx_wrap = (DIM_W'(wx_q) + 1'b1 >= width_q);
  assign wy_wrap = (DIM_W'(wy_q) + 1'b1 >= height_q);
  assign wz_wrap = (DIM_W'(wz_q) + 1'b1 >= depth_q);

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (acc_emit) state_d = ST_READ;
      ST_READ:   if (step_q == NB_DONE) state_d = ST_SQUARE;
      ST_SQUARE: if (step_q == SQ_DONE) state_d = ST_START;
      ST_START:  state_d = ST_ROOT;
      ST_ROOT:   if (sq_done) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
    cfg_ready_o   = (state_q == ST_IDLE);
    sq_start      = (state_q == ST_START);
    out_load      = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // ------------------------------------------------- registers and pointers
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_WIDTH_X:  width_d  = clamp_dim(cfg_data_i, DIM_MAX_X);
        REG_HEIGHT_Y: height_d = clamp_dim(cfg_data_i, DIM_MAX_Y);
        REG_DEPTH_Z:  depth_d  = clamp_dim(cfg_data_i, DIM_MAX_Z);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_RESET;
      height_q  <= DIM_RESET;
      depth_q   <= DIM_RESET;
      plane_q   <= PEND_W'(32'(DIM_RESET) * 32'(DIM_RESET));
      pending_q <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      wz_q      <= '0;
      ex_q      <= '0;
      ey_q      <= '0;
      ez_q      <= '0;
      bank_q    <= 1'b0;
    end else if (cfg_hit) begin
      width_q   <= width_d;
      height_q  <= height_d;
      depth_q   <= depth_d;
      plane_q   <= PEND_W'(width_d) * PEND_W'(height_d);
      pending_q <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      wz_q      <= '0;
      ex_q      <= '0;
      ey_q      <= '0;
      ez_q      <= '0;
      bank_q    <= 1'b0;
    end else if (acc) begin
      if (acc_emit) begin
        ex_q <= ex_wrap ? '0 : ex_q + 1'b1;
        if (ex_wrap) begin
          ey_q <= ey_wrap ? '0 : ey_q + 1'b1;
          if (ey_wrap) begin
            ez_q <= ez_wrap ? '0 : ez_q + 1'b1;
          end
        end
      end
      if (s_axis_tuser) begin
        if (drain_due) pending_q <= pending_q - 1'b1;
      end else begin
        if (!voxel_emit) pending_q <= pending_q + 1'b1;
        wx_q <= wx_wrap ? '0 : wx_q + 1'b1;
        if (wx_wrap) begin
          wy_q <= wy_wrap ? '0 : wy_q + 1'b1;
          if (wy_wrap) begin
            bank_q <= !bank_q;
            wz_q   <= wz_wrap ? '0 : wz_q + 1'b1;
          end
        end
      end
    end
  end

  // item context, taken with the request
  always_ff @(posedge clk_i) begin
    if (acc_emit) begin
      item_idx_q <= {ey_q, ex_q};
      inner_q[0] <= (ex_q != '0) && (DIM_W'(ex_q) + 1'b1 < width_q);
      inner_q[1] <= (ey_q != '0) && (DIM_W'(ey_q) + 1'b1 < height_q);
      inner_q[2] <= (ez_q != '0) && (DIM_W'(ez_q) + 1'b1 < depth_q);
      next_smp_q <= s_axis_tuser ? '0 : s_axis_tdata[SAMPLE_W-1:0];
      cur_bank_q <= !bank_q;
      last_vox_q <= ex_wrap && ey_wrap && ez_wrap;
    end
  end

  // ------------------------------------------------------------ plane stores
  always_comb begin
    unique case (step_q)
      NB_LEFT:  nb_addr = item_idx_q - AW'(1);
      NB_RIGHT: nb_addr = item_idx_q + AW'(1);
      NB_UP:    nb_addr = item_idx_q - AW'(MAX_X);
      NB_DOWN:  nb_addr = item_idx_q + AW'(MAX_X);
      default:  nb_addr = item_idx_q;
    endcase
  end

  // centre of the older plane is read in the request cycle, before the write
  assign rd_addr  = (state_q == ST_IDLE) ? {ey_q, ex_q} : nb_addr;
  assign wr_addr  = {wy_q, wx_q};
  assign we_older = acc_voxel && !bank_q;
  assign we_newer = acc_voxel && bank_q;

  always_ff @(posedge clk_i) begin
    if (we_older) older_mem[wr_addr] <= s_axis_tdata[SAMPLE_W-1:0];
    older_rd_q <= older_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_newer) newer_mem[wr_addr] <= s_axis_tdata[SAMPLE_W-1:0];
    newer_rd_q <= newer_mem[rd_addr];
  end

  assign cur_rd = cur_bank_q ? newer_rd_q : older_rd_q;
  assign nb_sel = 2'(step_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      if (step_q == NB_LEFT) begin
        prev_q <= cur_bank_q ? older_rd_q : newer_rd_q;
      end else begin
        nb_q[nb_sel] <= cur_rd;
      end
    end
  end

  // ------------------------------------------------------ squares and root
  always_comb begin
    unique case (step_q)
      3'd0:    diff = inner_q[0] ? DIFF_W'(nb_q[0]) - DIFF_W'(nb_q[1]) : '0;
      3'd1:    diff = inner_q[1] ? DIFF_W'(nb_q[2]) - DIFF_W'(nb_q[3]) : '0;
      3'd2:    diff = inner_q[2] ? DIFF_W'(prev_q) - DIFF_W'(next_smp_q) : '0;
      default: diff = '0;
    endcase
    prod = diff * diff;
  end

  always_ff @(posedge clk_i) begin
    if (acc_emit) begin
      sum_q <= '0;
    end else if (state_q == ST_SQUARE) begin
      sq_q <= prod[SQ_W-1:0];
      if (step_q != '0) sum_q <= sum_q + SUM_W'(sq_q);
    end
  end

  vgm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({sum_q, 4'b0000}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // ------------------------------------------------------------ output side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mag_q   <= MAG_W'(sq_root);
      tlast_q <= last_vox_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-MAG_W){1'b0}}, mag_q};
  assign m_axis_tlast  = tlast_q;

  // ------------------------------------------------------------- assertions
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= plane_q)
    else $error("pending count above plane size");

  a_emit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_voxel && voxel_emit) |-> ({wy_q, wx_q} == {ey_q, ex_q}))
    else $error("emit and write positions differ on a voxel result");

  a_emit_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_emit |=> (state_q == ST_READ && step_q == NB_LEFT))
    else $error("result request did not start the neighbour reads");

  a_root_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_ROOT)
    else $error("square root finished outside its wait state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(mag_q)))
    else $error("held result was overwritten");

endmodule

`default_nettype wire

// ----- tb/volume_gradient_magnitude_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for volume_gradient_magnitude_top: streams voxel volumes and drain
// requests under random handshake pressure and checks every result against an
// in-bench gradient predictor. Depends on vgm_pkg and the block's RTL.

module volume_gradient_magnitude_top_tb;
  import vgm_pkg::*;

  localparam int unsigned SETTLE = 64;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_LEN = 400;
  localparam logic KIND_VOXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             volume_end;
  } grad_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [DIM_W-1:0]       cfg_data_i = '0;

  int unsigned src_idle_pct = 15;
  int unsigned sink_idle_pct = 79;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_done = 0;
  int unsigned fail_cnt = 0;

  // predictor state
  logic [SAMPLE_W-1:0] grad_mem [2][PLANE_CELLS];
  bit                  grad_seen [2][PLANE_CELLS];
  int unsigned dim_x = MAX_X, dim_y = MAX_Y, dim_z = MAX_Z;
  int unsigned wr_x = 0, wr_y = 0, wr_z = 0;
  int unsigned em_x = 0, em_y = 0, em_z = 0;
  int unsigned pend = 0;
  bit          wr_bank = 1'b0;
  grad_result_t grad_expect_q[$];

  volume_gradient_magnitude_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= n) begin
        r = trial;
      end
    end
    return r;
  endfunction

  function automatic void grad_config(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] raw);
    int unsigned v, lim;
    case (idx)
      REG_WIDTH_X:  lim = MAX_X;
      REG_HEIGHT_Y: lim = MAX_Y;
      REG_DEPTH_Z:  lim = MAX_Z;
      default:      return;
    endcase
    v = raw;
    if (v == 0) begin
      v = 1;
    end else if (v > lim) begin
      v = lim;
    end
    case (idx)
      REG_WIDTH_X:  dim_x = v;
      REG_HEIGHT_Y: dim_y = v;
      default:      dim_z = v;
    endcase
    wr_x = 0; wr_y = 0; wr_z = 0;
    em_x = 0; em_y = 0; em_z = 0;
    pend = 0;
    wr_bank = 1'b0;
  endfunction

  // gradient of the voxel at the emit pointer; nxt is its sample one plane on
  function automatic grad_result_t grad_emit(input int signed nxt);
    int unsigned cb, pb, idx;
    longint signed dx, dy, dz;
    longint unsigned sq, root;
    grad_result_t r;
    cb = wr_bank ? 0 : 1;
    pb = wr_bank ? 1 : 0;
    idx = em_y * MAX_X + em_x;
    dx = 0; dy = 0; dz = 0;
    if (em_x > 0 && em_x + 1 < dim_x) begin
      dx = longint'($signed(grad_mem[cb][idx-1])) - longint'($signed(grad_mem[cb][idx+1]));
    end
    if (em_y > 0 && em_y + 1 < dim_y) begin
      dy = longint'($signed(grad_mem[cb][idx-MAX_X]))
         - longint'($signed(grad_mem[cb][idx+MAX_X]));
    end
    if (em_z > 0 && em_z + 1 < dim_z) begin
      dz = longint'($signed(grad_mem[pb][idx])) - longint'(nxt);
    end
    sq = dx * dx + dy * dy + dz * dz;
    root = int_sqrt(sq << 4);
    r.magnitude = root[MAG_W-1:0];
    r.volume_end = (em_x + 1 == dim_x) && (em_y + 1 == dim_y) && (em_z + 1 == dim_z);
    if (++em_x >= dim_x) begin
      em_x = 0;
      if (++em_y >= dim_y) begin
        em_y = 0;
        if (++em_z >= dim_z) begin
          em_z = 0;
        end
      end
    end
    return r;
  endfunction

  // returns 0 for a drain the block ignores
  function automatic bit grad_step(input logic kind, input logic [SAMPLE_W-1:0] smp);
    int unsigned slot;
    if (kind == KIND_DRAIN) begin
      if (pend == 0 || em_z + 1 != dim_z) begin
        return 1'b0;
      end
      grad_expect_q.push_back(grad_emit(0));
      pend--;
      return 1'b1;
    end
    if (pend >= dim_x * dim_y) begin
      grad_expect_q.push_back(grad_emit($signed(smp)));
    end else begin
      pend++;
    end
    slot = wr_y * MAX_X + wr_x;
    grad_mem[wr_bank][slot] = smp;
    grad_seen[wr_bank][slot] = 1'b1;
    if (++wr_x >= dim_x) begin
      wr_x = 0;
      if (++wr_y >= dim_y) begin
        wr_y = 0;
        wr_bank = ~wr_bank;
        if (++wr_z >= dim_z) begin
          wr_z = 0;
        end
      end
    end
    return 1'b1;
  endfunction

  // a drain now must not read a plane entry that was never stored
  function automatic bit drain_ok();
    int unsigned cb, idx;
    bit ok;
    ok = 1'b1;
    if (pend == 0 || em_z + 1 != dim_z) begin
      return 1'b1;
    end
    cb = wr_bank ? 0 : 1;
    idx = em_y * MAX_X + em_x;
    if (em_x > 0 && em_x + 1 < dim_x) begin
      ok &= grad_seen[cb][idx-1] & grad_seen[cb][idx+1];
    end
    if (em_y > 0 && em_y + 1 < dim_y) begin
      ok &= grad_seen[cb][idx-MAX_X] & grad_seen[cb][idx+MAX_X];
    end
    return ok;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample(input int unsigned style,
                                                      input logic [SAMPLE_W-1:0] base);
    logic [SAMPLE_W-1:0] v;
    case (style)
      0: v = SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = base + SAMPLE_W'($urandom_range(31)) - 16'd16;
    endcase
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
    if ($urandom_range(11) == 0) begin
      return '0;
    end
    return DIM_W'($urandom_range(1, hi));
  endfunction

  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    if (grad_step(kind, smp)) begin
      items_done++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (grad_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic go_idle();
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    grad_config(idx, val);
    @(negedge clk_i);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] wx, input logic [DIM_W-1:0] hy,
                          input logic [DIM_W-1:0] dz);
    go_idle();
    cfg_write(REG_WIDTH_X, wx);
    cfg_write(REG_HEIGHT_Y, hy);
    cfg_write(REG_DEPTH_Z, dz);
    cfg_valid_i <= 1'b0;
  endtask

  // full-scale steps on all three axes meet at the centre voxel
  task automatic test_extreme_cube();
    set_dims(9'd3, 9'd3, 9'd3);
    send_item(KIND_DRAIN, 16'hFFFF);
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          if (z == 1 && y == 1 && x == 0) begin
            send_item(KIND_DRAIN, 16'h0000);
          end
          send_item(KIND_VOXEL, (x == 0 || y == 0 || z == 0) ? 16'h7FFF : 16'h8000);
        end
      end
    end
    while (pend != 0) begin
      send_item(KIND_DRAIN, 16'h5A5A);
    end
    send_item(KIND_DRAIN, 16'hA5A5);
  endtask

  task automatic test_register_limits();
    set_dims(9'd256, 9'd0, 9'd511);
    repeat (296) send_item(KIND_VOXEL, SAMPLE_W'($urandom));
    set_dims(9'd1, 9'd256, 9'd1);
    repeat (256) send_item(KIND_VOXEL, SAMPLE_W'($urandom));
    repeat (24) send_item(KIND_DRAIN, SAMPLE_W'($urandom));
    set_dims(9'd1, 9'd1, 9'd256);
    for (int i = 0; i < 256; i++) begin
      if (i == 128) begin
        // write to an unmapped index must leave the stream alone
        go_idle();
        cfg_write(REG_UNUSED, 9'h1FF);
        cfg_valid_i <= 1'b0;
      end
      send_item(KIND_VOXEL, SAMPLE_W'($urandom));
    end
    send_item(KIND_DRAIN, SAMPLE_W'($urandom));
    repeat (3) send_item(KIND_VOXEL, SAMPLE_W'($urandom));
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    set_dims(9'd4, 9'd4, 9'd3);
    for (int c = 0; c < 48; c++) begin
      if (c == 20) begin
        hold_req++;
      end
      if (c == 34) begin
        wait_drained();
      end
      send_item(KIND_VOXEL, SAMPLE_W'($urandom));
    end
    while (pend != 0) begin
      send_item(KIND_DRAIN, SAMPLE_W'($urandom));
    end
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned snk_pct,
                             input int unsigned n_items);
    int unsigned goal, cells, nvol, lim, style;
    logic [SAMPLE_W-1:0] base;
    src_idle_pct = src_pct;
    sink_idle_pct = snk_pct;
    goal = items_done + n_items;
    while (items_done < goal) begin
      set_dims(pick_dim(8), pick_dim(6), pick_dim(5));
      cells = dim_x * dim_y * dim_z;
      nvol = $urandom_range(1, 3);
      style = $urandom_range(2);
      base = SAMPLE_W'($urandom);
      for (int v = 0; v < nvol; v++) begin
        // now and then the last volume is cut short
        lim = (v + 1 == nvol && $urandom_range(5) == 0) ? $urandom_range(cells - 1) : cells;
        for (int c = 0; c < lim; c++) begin
          if ($urandom_range(24) == 0 && drain_ok()) begin
            send_item(KIND_DRAIN, SAMPLE_W'($urandom));
          end
          send_item(KIND_VOXEL, rand_sample(style, base));
        end
      end
      if ($urandom_range(3) != 0) begin
        while (pend != 0 && em_z + 1 == dim_z && drain_ok()) begin
          send_item(KIND_DRAIN, SAMPLE_W'($urandom));
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    grad_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grad_expect_q.size() == 0) begin
        $error("unexpected result: magnitude %0d", m_axis_tdata[MAG_W-1:0]);
        fail_cnt++;
      end else begin
        want = grad_expect_q.pop_front();
        if (m_axis_tdata[MAG_W-1:0] !== want.magnitude) begin
          $error("magnitude: expected %0d, got %0d", want.magnitude,
                 m_axis_tdata[MAG_W-1:0]);
          fail_cnt++;
        end
        if (m_axis_tlast !== want.volume_end) begin
          $error("volume_end: expected %0b, got %0b", want.volume_end, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extreme_cube();
    test_register_limits();
    test_random(15, 79, 150);
    test_random(79, 15, 150);
    test_backpressure();
    test_random(0, 0, 150);
    go_idle();
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/vgm_pkg.sv
src/vgm_isqrt.sv
src/volume_gradient_magnitude_top.sv
tb/volume_gradient_magnitude_top_tb.sv
